// ===== design/mlmi_pkg.sv =====
// Shared types and constants for the multi-axis linear move interpolator.
// Used by the serial arithmetic units, the core and the port checker.
// Depends on nothing.
package mlmi_pkg;

  // Field widths fixed by the interface.
  localparam int AXIS_W      = 12;
  localparam int AXES_DEF    = 4;
  localparam int PORT_AXES   = 4;
  localparam int SPEED_W     = 8;
  localparam int PROD_W      = 2 * AXIS_W;
  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = PORT_AXES * AXIS_W;
  localparam int PADDR_W     = 3;
  localparam int APB_DW      = 32;

  // Register index of the speed register (address bit 2 upward).
  localparam logic [PADDR_W-3:0] REG_SPEED = '0;

  // Command codes carried in the input tuser.
  typedef enum logic [IN_TUSER_W-1:0] {
    FN_SET   = 2'd0,
    FN_BEGIN = 2'd1,
    FN_TICK  = 2'd2
  } func_t;

  // Status of a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== design/mlmi_ser_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on mlmi_pkg for the status struct.
module mlmi_ser_mul #(
  parameter int AW = 12,
  parameter int BW = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [AW-1:0]          a,
  input  logic [BW-1:0]          b,
  output mlmi_pkg::unit_stat_t   stat,
  output logic [AW+BW-1:0]       prod
);
  import mlmi_pkg::*;

  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0] a_reg;
  logic [AW-1:0] hi;
  logic [BW-1:0] lo;
  logic [CW-1:0] cnt;
  logic          done;
  logic [AW:0]   sum;

  // Add the multiplicand when the low bit of the shifting multiplier is set.
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, a_reg} : {(AW + 1){1'b0}});

  // Control: counts the remaining multiplier bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(BW);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: product bits shift in from the top as multiplier bits leave.
  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      hi    <= '0;
      lo    <= b;
    end else if (cnt != '0) begin
      hi <= sum[AW:1];
      lo <= {sum[0], lo[BW-1:1]};
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.done = done;
  assign prod      = {hi, lo};

endmodule

// ===== design/mlmi_ser_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on mlmi_pkg for the status struct.
module mlmi_ser_div #(
  parameter int NW = 24,
  parameter int DW = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [NW-1:0]          dividend,
  input  logic [DW-1:0]          divisor,
  output mlmi_pkg::unit_stat_t   stat,
  output logic [NW-1:0]          quo,
  output logic [DW-1:0]          rem
);
  import mlmi_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          done;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // Bring down the next dividend bit and try a subtraction.
  assign trial = {rem, quo[NW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = ~diff[DW];

  // Control: counts the remaining quotient bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(NW);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the remainder stays below the divisor, so it fits DW bits.
  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (cnt != '0) begin
      rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo <= {quo[NW-2:0], ge};
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.done = done;

endmodule

// ===== design/multi_axis_linear_move_interpolator_core.sv =====
// Top level of the multi-axis linear move interpolator.
// Depends on mlmi_pkg, mlmi_ser_mul and mlmi_ser_div.
//
// Channel   Dir  Handshake                  Payload
// s_axis    in   tvalid/tready              tdata: targets, step_count; tuser: func
// m_axis    out  tvalid/tready              tdata: positions; tlast: last; tuser: busy
// apb       in   psel/penable/pwrite/pready speed register at byte address 0
//
// One word is in work at a time. Set, idle tick and unused codes go straight
// to the emit state and on to the output register. Begin scans every axis and
// takes the step count, or the speed divide (24-bit serial) when it is zero.
// A moving tick runs, per axis, a 12-bit serial multiply and a 24-bit serial
// divide through one shared pair of units.
// Reset is synchronous and clears positions, control and the output valid.
// A stalled output word holds while the next input word may already be taken.
module multi_axis_linear_move_interpolator_core #(
  parameter int AXES = mlmi_pkg::AXES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // tdata: target_base, target_body, target_neck, target_claw, step_count
  input  logic [mlmi_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // tuser: func
  input  logic [mlmi_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: pos_base, pos_body, pos_neck, pos_claw
  output logic [mlmi_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // tuser: busy_res
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mlmi_pkg::PADDR_W-1:0]       paddr,
  input  logic [mlmi_pkg::APB_DW-1:0]        pwdata,
  output logic [mlmi_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);
  import mlmi_pkg::*;

  localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;
  localparam logic [AXW-1:0] AX_LAST = AXW'(AXES - 1);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_SCAN      = 10'b0000000010,
    S_NDIV_GO   = 10'b0000000100,
    S_NDIV_WAIT = 10'b0000001000,
    S_MUL_GO    = 10'b0000010000,
    S_MUL_WAIT  = 10'b0000100000,
    S_DIV_GO    = 10'b0001000000,
    S_DIV_WAIT  = 10'b0010000000,
    S_UPD       = 10'b0100000000,
    S_EMIT      = 10'b1000000000
  } state_t;

  state_t state, state_next;

  logic [SPEED_W-1:0] speed;
  logic [AXIS_W-1:0]  pos    [AXES];
  logic [AXIS_W-1:0]  mstart [AXES];
  logic [AXIS_W-1:0]  mtarget[AXES];
  logic [AXIS_W-1:0]  in_tgt [AXES];
  logic [AXIS_W-1:0]  step_index;
  logic [AXIS_W-1:0]  total;
  logic               moving;
  logic [AXW-1:0]     ax;
  logic [AXIS_W-1:0]  maxd;
  logic [5*AXIS_W-1:0] in_word;
  logic               res_last;
  logic               res_busy;

  logic               s_acc;
  logic               out_free;
  func_t              func;

  // APB register access.
  logic               cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[PADDR_W-1:2] == REG_SPEED) ?
                  {{(APB_DW - SPEED_W){1'b0}}, speed} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= SPEED_W'(1);
    end else if (cfg_wr && (paddr[PADDR_W-1:2] == REG_SPEED)) begin
      speed <= pwdata[SPEED_W-1:0];
    end
  end

  // Axis targets from the latched input word; axes past the port take zero.
  for (genvar a = 0; a < AXES; a++) begin : g_tgt
    if (a < PORT_AXES) begin : g_port
      assign in_tgt[a] = in_word[a*AXIS_W +: AXIS_W];
    end else begin : g_zero
      assign in_tgt[a] = '0;
    end
  end

  // Output positions; port slots past the axis count read zero.
  logic [OUT_TDATA_W-1:0] pos_word;
  for (genvar a = 0; a < PORT_AXES; a++) begin : g_out
    if (a < AXES) begin : g_axis
      assign pos_word[a*AXIS_W +: AXIS_W] = pos[a];
    end else begin : g_none
      assign pos_word[a*AXIS_W +: AXIS_W] = '0;
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~m_axis_tvalid | m_axis_tready;
  assign func          = func_t'(s_axis_tuser);

  // Per-axis operands for the scan and the interpolation.
  logic [AXIS_W-1:0] cur_pos, cur_tgt, cur_st, cur_mt;
  logic [AXIS_W-1:0] scan_d, mag;
  logic              neg;
  assign cur_pos = pos[ax];
  assign cur_tgt = in_tgt[ax];
  assign cur_st  = mstart[ax];
  assign cur_mt  = mtarget[ax];
  assign scan_d  = (cur_tgt >= cur_pos) ? (cur_tgt - cur_pos) : (cur_pos - cur_tgt);
  assign neg     = (cur_mt < cur_st);
  assign mag     = neg ? (cur_st - cur_mt) : (cur_mt - cur_st);

  // Shared serial multiplier and divider.
  unit_stat_t         mul_stat, div_stat;
  logic               mul_start, div_start;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  div_num;
  logic [AXIS_W-1:0]  div_den;
  logic [PROD_W-1:0]  quo;
  logic [AXIS_W-1:0]  rem;
  logic [SPEED_W-1:0] sp;

  assign sp        = (speed == '0) ? SPEED_W'(1) : speed;
  assign mul_start = (state == S_MUL_GO) && !mul_stat.busy;
  assign div_start = ((state == S_DIV_GO) || (state == S_NDIV_GO)) && !div_stat.busy;
  assign div_num   = (state == S_NDIV_GO) ? {{(PROD_W - AXIS_W){1'b0}}, maxd} : prod;
  assign div_den   = (state == S_NDIV_GO) ? {{(AXIS_W - SPEED_W){1'b0}}, sp} : total;

  mlmi_ser_mul #(.AW(AXIS_W), .BW(AXIS_W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mag),
    .b     (step_index),
    .stat  (mul_stat),
    .prod  (prod)
  );

  mlmi_ser_div #(.NW(PROD_W), .DW(AXIS_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .stat     (div_stat),
    .quo      (quo),
    .rem      (rem)
  );

  // New axis position: floor division, so a negative delta rounds away from zero.
  logic [AXIS_W+1:0] up_sum, dn_dif;
  logic [AXIS_W-1:0] new_pos;
  logic              rnz;
  logic              tick_last;
  assign rnz     = (rem != '0);
  assign up_sum  = {2'b00, cur_st} + {2'b00, quo[AXIS_W-1:0]};
  assign dn_dif  = {2'b00, cur_st} - {2'b00, quo[AXIS_W-1:0]} - {{(AXIS_W + 1){1'b0}}, rnz};
  always_comb begin
    if (neg) begin
      new_pos = dn_dif[AXIS_W+1] ? '0 : dn_dif[AXIS_W-1:0];
    end else begin
      new_pos = (up_sum[AXIS_W+1:AXIS_W] != 2'b00) ? {AXIS_W{1'b1}} : up_sum[AXIS_W-1:0];
    end
  end
  assign tick_last = ({1'b0, step_index} + 1'b1) >= {1'b0, total};

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_acc) begin
          unique case (func)
            FN_BEGIN: state_next = S_SCAN;
            FN_TICK:  state_next = moving ? S_MUL_GO : S_EMIT;
            default:  state_next = S_EMIT;
          endcase
        end
      end
      S_SCAN: begin
        if (ax == AX_LAST) begin
          state_next = (in_word[4*AXIS_W +: AXIS_W] != '0) ? S_EMIT : S_NDIV_GO;
        end
      end
      S_NDIV_GO:   if (div_start) state_next = S_NDIV_WAIT;
      S_NDIV_WAIT: if (div_stat.done) state_next = S_EMIT;
      S_MUL_GO:    if (mul_start) state_next = S_MUL_WAIT;
      S_MUL_WAIT:  if (mul_stat.done) state_next = S_DIV_GO;
      S_DIV_GO:    if (div_start) state_next = S_DIV_WAIT;
      S_DIV_WAIT:  if (div_stat.done) state_next = S_UPD;
      S_UPD:       state_next = (ax == AX_LAST) ? S_EMIT : S_MUL_GO;
      S_EMIT:      if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Control state, positions and move bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      moving     <= 1'b0;
      step_index <= '0;
      total      <= AXIS_W'(1);
      for (int a = 0; a < AXES; a++) begin
        pos[a] <= '0;
      end
    end else begin
      state <= state_next;
      if (s_acc && (func == FN_SET)) begin
        for (int a = 0; a < AXES; a++) begin
          if (a < PORT_AXES) begin
            pos[a] <= s_axis_tdata[a*AXIS_W +: AXIS_W];
          end else begin
            pos[a] <= '0;
          end
        end
        moving <= 1'b0;
      end
      // Begin: fix the increment count once the scan is through.
      if ((state == S_SCAN) && (ax == AX_LAST)) begin
        step_index <= '0;
        moving     <= 1'b1;
        if (in_word[4*AXIS_W +: AXIS_W] != '0) begin
          total <= in_word[4*AXIS_W +: AXIS_W];
        end
      end
      if ((state == S_NDIV_WAIT) && div_stat.done) begin
        total <= (quo == '0) ? AXIS_W'(1) : quo[AXIS_W-1:0];
      end
      // Tick: update one axis, then close the increment after the last axis.
      if (state == S_UPD) begin
        pos[ax] <= new_pos;
        if (ax == AX_LAST) begin
          step_index <= step_index + 1'b1;
          if (tick_last) begin
            moving <= 1'b0;
          end
        end
      end
    end
  end

  // Payload registers: latched command, move endpoints, scan and result flags.
  always_ff @(posedge clk) begin
    if (s_acc) begin
      in_word  <= s_axis_tdata[5*AXIS_W-1:0];
      ax       <= '0;
      maxd     <= '0;
      res_last <= 1'b0;
      res_busy <= (func == FN_BEGIN) ||
                  ((func != FN_SET) && (func != FN_TICK) && moving);
    end
    if (state == S_SCAN) begin
      mstart[ax]  <= cur_pos;
      mtarget[ax] <= cur_tgt;
      if (scan_d > maxd) begin
        maxd <= scan_d;
      end
      if (ax != AX_LAST) begin
        ax <= ax + 1'b1;
      end
    end
    if (state == S_UPD) begin
      if (ax != AX_LAST) begin
        ax <= ax + 1'b1;
      end else begin
        res_last <= tick_last;
        res_busy <= ~tick_last;
      end
    end
  end

  // Output register; it frees as the downstream side takes the word.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == S_EMIT) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && out_free) begin
      m_axis_tdata <= pos_word;
      m_axis_tlast <= res_last;
      m_axis_tuser <= res_busy;
    end
  end

endmodule

// ===== design/mlmi_checker.sv =====
// Port-level checks for the multi-axis linear move interpolator core.
// Depends on mlmi_pkg; bound to the core at the end of this file.
module mlmi_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic [mlmi_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input logic                               m_axis_tuser,
  input logic                               m_axis_tlast,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready
);
  import mlmi_pkg::*;

  // A stalled output word keeps its positions and last flag.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // The final increment of a move always leaves the block idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser)
    else $error("last increment reported with move still busy");

  // One word in work at a time: an accepted word closes the input.
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again before the word was processed");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind multi_axis_linear_move_interpolator_core mlmi_checker u_mlmi_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

// ===== bench/tb_multi_axis_linear_move_interpolator_core.sv =====
// Self-checking testbench for the multi-axis linear move interpolator core.
// A scoreboard class predicts each output word from the accepted input words and the speed
// register; plain tasks drive the input stream and the APB port. Depends on mlmi_pkg.
`timescale 1ns / 1ps

module tb_multi_axis_linear_move_interpolator_core;
  import mlmi_pkg::*;

  localparam logic [1:0]         FN_UNUSED  = 2'd3;
  localparam logic [PADDR_W-1:0] SPEED_ADDR = {REG_SPEED, 2'b00};
  localparam int                 WORDS_WANTED = 750;
  localparam int                 PHASE_WORDS  = 150;
  localparam int                 HOLD_CYCLES  = 800;

  // One predicted output word.
  typedef struct {
    logic [OUT_TDATA_W-1:0] pos;
    logic                   last;
    logic                   busy;
  } move_result_t;

  // Tracks the interpolator state and holds the output words still to come.
  class move_scoreboard;
    logic [7:0]  speed;
    logic [11:0] axis_pos[4];
    logic [11:0] move_from[4];
    logic [11:0] move_to[4];
    logic [11:0] step_idx;
    logic [11:0] step_total;
    logic        moving;
    move_result_t pending_q[$];
    int          errors;

    function new();
      speed = 8'd1;
      foreach (axis_pos[a]) begin
        axis_pos[a]  = '0;
        move_from[a] = '0;
        move_to[a]   = '0;
      end
      step_idx   = '0;
      step_total = 12'd1;
      moving     = 1'b0;
      errors     = 0;
    endfunction

    // Update the state for an accepted input word and queue the word it produces.
    function void note_word(logic [1:0] fn, logic [63:0] d);
      logic [11:0] tv, spread, maxd, steps;
      longint num, den, q, p;
      int sp;
      logic lst;
      move_result_t r;
      steps = d[59:48];
      lst = 1'b0;
      case (fn)
        FN_SET: begin
          for (int a = 0; a < 4; a++) axis_pos[a] = d[12*a +: 12];
          moving = 1'b0;
        end
        FN_BEGIN: begin
          maxd = '0;
          for (int a = 0; a < 4; a++) begin
            tv = d[12*a +: 12];
            spread = (tv >= axis_pos[a]) ? tv - axis_pos[a] : axis_pos[a] - tv;
            move_from[a] = axis_pos[a];
            move_to[a]   = tv;
            if (spread > maxd) maxd = spread;
          end
          if (steps != 0) begin
            step_total = steps;
          end else begin
            // A speed of zero behaves as one.
            sp = (speed == 0) ? 1 : int'(speed);
            spread = 12'(maxd / sp);
            step_total = (spread == 0) ? 12'd1 : spread;
          end
          step_idx = '0;
          moving = 1'b1;
        end
        FN_TICK: begin
          // An idle tick just repeats the positions.
          if (moving) begin
            for (int a = 0; a < 4; a++) begin
              num = longint'(move_to[a]) - longint'(move_from[a]);
              num = num * longint'(step_idx);
              den = longint'(step_total);
              // Quotient rounded toward minus infinity.
              if (num >= 0) q = num / den;
              else q = -((-num + den - 1) / den);
              p = longint'(move_from[a]) + q;
              if (p < 0) p = 0;
              if (p > 4095) p = 4095;
              axis_pos[a] = p[11:0];
            end
            lst = (int'(step_idx) + 1 >= int'(step_total));
            step_idx = step_idx + 12'd1;
            if (lst) moving = 1'b0;
          end
        end
        default: ;
      endcase
      r.pos  = {axis_pos[3], axis_pos[2], axis_pos[1], axis_pos[0]};
      r.last = lst;
      r.busy = moving;
      pending_q.push_back(r);
    endfunction

    function void compare(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      end
    endfunction

    // Check one output word against the oldest prediction.
    function void check_word(logic [OUT_TDATA_W-1:0] pos, logic lst, logic busy);
      move_result_t e;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected output word: expected none, actual pos=%h last=%b busy=%b",
                 $time, pos, lst, busy);
        return;
      end
      e = pending_q.pop_front();
      for (int a = 0; a < 4; a++)
        compare($sformatf("axis %0d position", a), 32'(e.pos[12*a +: 12]),
                32'(pos[12*a +: 12]));
      compare("last", 32'(e.last), 32'(lst));
      compare("busy", 32'(e.busy), 32'(busy));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [PADDR_W-1:0]     paddr = '0;
  logic [APB_DW-1:0]      pwdata = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  move_scoreboard sb;
  int burst_left = 0;
  int words_sent = 0;
  int rx_cycle = 0;
  int rx_mode = 0;
  int hold_left = 0;

  multi_axis_linear_move_interpolator_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 100 MHz clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Output receiver: it picks a random stall mode (always ready, coin toss or mostly stalled), with two long hold-offs.
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle == 20000 || rx_cycle == 90000) hold_left = HOLD_CYCLES;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 2);
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Output monitor.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready)
      sb.check_word(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  function automatic logic [63:0] pack_word(logic [11:0] t0, logic [11:0] t1, logic [11:0] t2,
                                            logic [11:0] t3, logic [11:0] steps);
    return {4'b0, steps, t3, t2, t1, t0};
  endfunction

  // Targets drawn fully at random, near the current positions, or at the rails.
  function automatic logic [63:0] rand_word(int style, logic [11:0] steps);
    int v;
    logic [63:0] w;
    w = '0;
    for (int a = 0; a < 4; a++) begin
      case (style)
        0: v = $urandom_range(0, 4095);
        1: v = int'(sb.axis_pos[a]) + int'($urandom_range(0, 80)) - 40;
        default: v = $urandom_range(0, 1) ? 4095 : 0;
      endcase
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      w[12*a +: 12] = v[11:0];
    end
    w[59:48] = steps;
    return w;
  endfunction

  // Offer one input word; the sender works in bursts separated by random gaps.
  task automatic send_word(input logic [1:0] fn, input logic [63:0] d);
    int gap;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= d;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_word(fn, d);
    burst_left--;
    words_sent++;
  endtask

  // Stop offering and wait until every predicted word has come out.
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write the speed register, then return the bus to idle.
  task automatic apb_write(input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SPEED_ADDR;
    pwdata  <= {24'b0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.speed = val;
    @(posedge clk);
  endtask

  task automatic apb_read_check();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= SPEED_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.compare("speed readback", {24'b0, sb.speed}, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // An optional set, a begin with random targets and count, then ticks with stray unused codes, sometimes cut short.
  task automatic random_move();
    int style, cap, n;
    logic [11:0] steps;
    if ($urandom_range(0, 3) == 0)
      send_word(FN_SET, rand_word($urandom_range(0, 2), 12'($urandom)));
    style = $urandom_range(0, 2);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: steps = 12'($urandom_range(1, 8));
      4: steps = 12'($urandom_range(9, 40));
      5: steps = 12'($urandom);
      default: steps = '0;
    endcase
    send_word(FN_BEGIN, rand_word(style, steps));
    cap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 24;
    n = 0;
    while (sb.moving && n < cap) begin
      if ($urandom_range(0, 15) == 0) send_word(FN_UNUSED, rand_word(0, 12'($urandom)));
      send_word(FN_TICK, rand_word(0, 12'($urandom)));
      n++;
    end
    if ($urandom_range(0, 3) == 0) send_word(FN_TICK, rand_word(0, 12'($urandom)));
  endtask

  // Main stimulus.
  initial begin
    int phase_no;
    int next_phase;
    logic [7:0] spd;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_read_check();

    // Idle tick and unused code straight after reset, then the rails.
    send_word(FN_TICK, pack_word(0, 0, 0, 0, 0));
    send_word(FN_UNUSED, pack_word(4095, 4095, 4095, 4095, 4095));
    send_word(FN_SET, pack_word(4095, 4095, 4095, 4095, 4095));
    send_word(FN_SET, pack_word(0, 4095, 2730, 1365, 0));
    // Three-step move with some deltas that do not divide evenly, some negative.
    send_word(FN_BEGIN, pack_word(4095, 0, 1366, 2731, 3));
    send_word(FN_TICK, pack_word(0, 0, 0, 0, 0));
    send_word(FN_UNUSED, pack_word(0, 0, 0, 0, 0));
    send_word(FN_TICK, pack_word(0, 0, 0, 0, 0));
    send_word(FN_TICK, pack_word(0, 0, 0, 0, 0));
    send_word(FN_TICK, pack_word(0, 0, 0, 0, 0));
    // One-step move ends on its first tick.
    send_word(FN_BEGIN, pack_word(100, 200, 300, 400, 1));
    send_word(FN_TICK, pack_word(0, 0, 0, 0, 0));
    // Automatic count with no travel falls back to one increment.
    send_word(FN_SET, pack_word(10, 20, 30, 40, 0));
    send_word(FN_BEGIN, pack_word(10, 20, 30, 40, 0));
    send_word(FN_TICK, pack_word(0, 0, 0, 0, 0));
    // Automatic count at speed one, cancelled by a set mid-move.
    send_word(FN_BEGIN, pack_word(15, 20, 30, 35, 0));
    send_word(FN_TICK, pack_word(0, 0, 0, 0, 0));
    send_word(FN_TICK, pack_word(0, 0, 0, 0, 0));
    send_word(FN_SET, pack_word(7, 7, 7, 7, 0));
    send_word(FN_TICK, pack_word(0, 0, 0, 0, 0));
    // Longest count, interrupted by a new begin.
    send_word(FN_BEGIN, pack_word(4095, 0, 4095, 0, 4095));
    send_word(FN_TICK, pack_word(0, 0, 0, 0, 0));
    send_word(FN_TICK, pack_word(0, 0, 0, 0, 0));
    send_word(FN_BEGIN, pack_word(0, 4095, 0, 4095, 2));
    send_word(FN_TICK, pack_word(0, 0, 0, 0, 0));
    send_word(FN_TICK, pack_word(0, 0, 0, 0, 0));

    // Full-scale automatic move at the highest speed.
    wait_drain();
    apb_write(8'd255);
    apb_read_check();
    send_word(FN_SET, pack_word(0, 0, 4095, 4095, 0));
    send_word(FN_BEGIN, pack_word(4095, 4095, 0, 0, 0));
    while (sb.moving) send_word(FN_TICK, pack_word(0, 0, 0, 0, 0));

    // Random phases, each under a new speed setting.
    phase_no = 0;
    next_phase = words_sent;
    while (words_sent < WORDS_WANTED) begin
      if (words_sent >= next_phase) begin
        wait_drain();
        case (phase_no % 5)
          0: spd = 8'd0;
          1: spd = 8'($urandom_range(2, 254));
          2: spd = 8'd1;
          3: spd = 8'd255;
          default: spd = 8'($urandom_range(64, 255));
        endcase
        apb_write(spd);
        apb_read_check();
        phase_no++;
        next_phase = words_sent + PHASE_WORDS;
      end
      if ($urandom_range(0, 9) == 0)
        send_word(2'($urandom_range(0, 3)), rand_word(0, 12'($urandom)));
      else random_move();
    end

    // Let the last words drain, then allow for any stray output.
    wait_drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mlmi_pkg.sv
design/mlmi_ser_mul.sv
design/mlmi_ser_div.sv
design/multi_axis_linear_move_interpolator_core.sv
design/mlmi_checker.sv
bench/tb_multi_axis_linear_move_interpolator_core.sv
